// ===== hdl/integer_to_radix_digits_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer to radix digits unit
// Shared property wrappers used by the unit's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_UNIT_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ITRD_ASSERT_IMPLIES(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ITRD_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg
// Types, constants and helper functions for the integer to radix digits unit.
// ----------------------------------------------------------------------------
package itrd_pkg;

   localparam int IN_WIDTH    = 32;
   localparam int BASE_WIDTH  = 5;
   localparam int CHAR_WIDTH  = 8;
   localparam int DIGIT_WIDTH = 4;

   // Width of the word actually converted (8 to 64)
   localparam int VALUE_WIDTH = 32;

   // Divider retires STEP_BITS quotient bits per cycle
   localparam int STEP_BITS   = 8;
   localparam int DIV_STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_WIDTH   = DIV_STEPS * STEP_BITS;
   localparam int DSTEP_WIDTH = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Digit stack: at most VALUE_WIDTH digits (radix two)
   localparam int DCOUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int DIDX_WIDTH   = $clog2(VALUE_WIDTH);

   localparam logic [BASE_WIDTH-1:0] MIN_RADIX     = 5'd2;
   localparam logic [BASE_WIDTH-1:0] MAX_RADIX     = 5'd16;
   localparam logic [BASE_WIDTH-1:0] DECIMAL_RADIX = 5'd10;
   localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR    = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] ZERO_CHAR     = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] ALPHA_BASE    = 8'h37;   // 'A' - 10
   localparam logic [DIGIT_WIDTH-1:0] DECIMAL_DIGITS = 4'd10;

   typedef struct packed {
      logic [IN_WIDTH-1:0]   value_bits;
      logic [BASE_WIDTH-1:0] base;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_ctrl_type;

   function automatic logic [BASE_WIDTH-1:0] sat_radix(input logic [BASE_WIDTH-1:0] base);
      logic [BASE_WIDTH-1:0] r;
      if (base < MIN_RADIX) begin
         r = MIN_RADIX;
      end else if (base > MAX_RADIX) begin
         r = MAX_RADIX;
      end else begin
         r = base;
      end
      return r;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d < DECIMAL_DIGITS) begin
         c = ZERO_CHAR + CHAR_WIDTH'(d);
      end else begin
         c = ALPHA_BASE + CHAR_WIDTH'(d);
      end
      return c;
   endfunction

endpackage

// ===== hdl/integer_to_radix_digits_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a word to ASCII digits in radix 2..16, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one word and a radix; the radix is saturated to 2..16.
//   Radix ten reads the word as two's complement and prefixes '-' when
//   negative; other radices read it as unsigned. Zero gives a single '0'.
//   rsp channel returns the characters most significant first, one per
//   transfer, with last set on the final character of the number.
//   req_stall is high from the transfer of a word until its final character
//   has been loaded into the output register.
// Operation:
//   Each digit takes one pass through the shared divider, which retires
//   eight quotient bits per cycle; the digits are then emitted as
//   characters, one per cycle while rsp is not stalled. A new word is
//   accepted only after the final character of the last one is loaded.
// Reset clears the sequencer, the output valid and the digit stack count.
// A stalled rsp transfer holds its character; emission simply waits.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_unit_macros.svh"

module integer_to_radix_digits_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  itrd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itrd_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type                        state_ff;
   logic                             neg_ff;
   logic [itrd_pkg::BASE_WIDTH-1:0]  radix_ff;
   logic                             rsp_valid_ff;
   itrd_pkg::rsp_type                rsp_ff;

   logic [itrd_pkg::BASE_WIDTH-1:0]  radix_in;
   logic [itrd_pkg::VALUE_WIDTH-1:0] mag_in;
   logic [itrd_pkg::VALUE_WIDTH-1:0] abs_in;
   logic                             neg_in;
   logic                             req_xfer;
   logic                             out_free;
   logic                             rsp_load;
   logic                             quot_zero;

   logic                             div_start;
   logic [itrd_pkg::DIV_WIDTH-1:0]   div_dividend;
   logic [itrd_pkg::BASE_WIDTH-1:0]  div_radix;
   itrd_pkg::div_status_type         div_status;
   logic [itrd_pkg::DIV_WIDTH-1:0]   div_quotient;
   logic [itrd_pkg::DIGIT_WIDTH-1:0] div_remainder;

   itrd_pkg::stack_ctrl_type         stack_ctrl;
   logic [itrd_pkg::DIGIT_WIDTH-1:0] stack_top;
   logic [itrd_pkg::DCOUNT_WIDTH-1:0] stack_count;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && (state_ff == ST_SIGN || state_ff == ST_EMIT);
   assign quot_zero = (div_quotient == '0);

   // Radix ten: negative words convert through their magnitude
   assign radix_in = itrd_pkg::sat_radix(req_data.base);
   assign mag_in   = itrd_pkg::VALUE_WIDTH'(req_data.value_bits);
   assign neg_in   = (radix_in == itrd_pkg::DECIMAL_RADIX) &&
                     mag_in[itrd_pkg::VALUE_WIDTH-1];
   assign abs_in   = neg_in ? (~mag_in + 1'b1) : mag_in;

   // First division from the input word, later ones from the last quotient
   assign div_start    = req_xfer ||
                         (state_ff == ST_DIVIDE && div_status.done && !quot_zero);
   assign div_dividend = (state_ff == ST_IDLE) ? itrd_pkg::DIV_WIDTH'(abs_in) : div_quotient;
   assign div_radix    = (state_ff == ST_IDLE) ? radix_in : radix_ff;

   assign stack_ctrl.clear = req_xfer;
   assign stack_ctrl.push  = (state_ff == ST_DIVIDE) && div_status.done;
   assign stack_ctrl.pop   = (state_ff == ST_EMIT) && out_free;

   itrd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   itrd_digit_stack u_digit_stack (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (stack_ctrl),
      .push_digit (div_remainder),
      .top_digit  (stack_top),
      .count      (stack_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  neg_ff   <= neg_in;
                  radix_ff <= radix_in;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_status.done && quot_zero) begin
                  state_ff <= neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  rsp_ff.character <= itrd_pkg::MINUS_CHAR;
                  rsp_ff.last      <= 1'b0;
                  state_ff         <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff.character <= itrd_pkg::digit_char(stack_top);
                  rsp_ff.last      <= (stack_count == itrd_pkg::DCOUNT_WIDTH'(1));
                  if (stack_count == itrd_pkg::DCOUNT_WIDTH'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ITRD_ASSERT_IMPLIES(a_start_not_busy, clock, reset, div_start, !div_status.busy,
      "divider restarted while busy")
   `ITRD_ASSERT_IMPLIES(a_emit_has_digit, clock, reset, state_ff == ST_EMIT,
      stack_count != '0, "emitting from an empty digit stack")
   `ITRD_ASSERT_IMPLIES(a_sign_not_last, clock, reset,
      rsp_valid_ff && rsp_ff.character == itrd_pkg::MINUS_CHAR, !rsp_ff.last,
      "minus sign flagged as last character")
   `ITRD_ASSERT_NEXT(a_final_digit_leaves, clock, reset,
      state_ff == ST_DIVIDE && div_status.done && quot_zero,
      state_ff == ST_SIGN || state_ff == ST_EMIT, "conversion did not move to emission")

endmodule

// ===== hdl/itrd_divider.sv =====
// ----------------------------------------------------------------------------
// itrd_divider
// Iterative divide by a small radix, STEP_BITS restoring steps per cycle.
// ----------------------------------------------------------------------------
module itrd_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [itrd_pkg::DIV_WIDTH-1:0]     dividend,
   input  logic [itrd_pkg::BASE_WIDTH-1:0]    radix,
   output itrd_pkg::div_status_type           status,
   output logic [itrd_pkg::DIV_WIDTH-1:0]     quotient,
   output logic [itrd_pkg::DIGIT_WIDTH-1:0]   remainder
);

   logic [itrd_pkg::DIV_WIDTH-1:0]   work_ff, work_in;
   logic [itrd_pkg::DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [itrd_pkg::BASE_WIDTH-1:0]  radix_ff;
   logic [itrd_pkg::DSTEP_WIDTH-1:0] cnt_ff;
   logic                             busy_ff;
   logic                             done_ff;

   // Dividend bits shift out of the top, quotient bits shift in at the bottom
   always_comb begin
      logic [itrd_pkg::DIGIT_WIDTH:0]   trial;
      logic [itrd_pkg::DIGIT_WIDTH-1:0] r;
      logic [itrd_pkg::STEP_BITS-1:0]   q_bits;
      r      = rem_ff;
      q_bits = '0;
      for (int i = 0; i < itrd_pkg::STEP_BITS; i++) begin
         trial = {r, work_ff[itrd_pkg::DIV_WIDTH-1-i]};
         if (trial >= radix_ff) begin
            trial = trial - radix_ff;
            q_bits[itrd_pkg::STEP_BITS-1-i] = 1'b1;
         end
         r = trial[itrd_pkg::DIGIT_WIDTH-1:0];
      end
      rem_in  = r;
      work_in = (work_ff << itrd_pkg::STEP_BITS) | itrd_pkg::DIV_WIDTH'(q_bits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            work_ff  <= dividend;
            rem_ff   <= '0;
            radix_ff <= radix;
            cnt_ff   <= itrd_pkg::DSTEP_WIDTH'(itrd_pkg::DIV_STEPS - 1);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            work_ff <= work_in;
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = work_ff;
   assign remainder   = rem_ff;

endmodule

// ===== hdl/itrd_digit_stack.sv =====
// ----------------------------------------------------------------------------
// itrd_digit_stack
// LIFO of digit values; digits arrive least significant first and leave
// most significant first.
// ----------------------------------------------------------------------------
module itrd_digit_stack (
   input  logic                                clock,
   input  logic                                reset,
   input  itrd_pkg::stack_ctrl_type            ctrl,
   input  logic [itrd_pkg::DIGIT_WIDTH-1:0]    push_digit,
   output logic [itrd_pkg::DIGIT_WIDTH-1:0]    top_digit,
   output logic [itrd_pkg::DCOUNT_WIDTH-1:0]   count
);

   logic [itrd_pkg::DIGIT_WIDTH-1:0]  digits_ff [itrd_pkg::VALUE_WIDTH];
   logic [itrd_pkg::DCOUNT_WIDTH-1:0] count_ff;
   logic [itrd_pkg::DCOUNT_WIDTH-1:0] top_pos;

   assign top_pos   = count_ff - 1'b1;
   assign top_digit = digits_ff[top_pos[itrd_pkg::DIDX_WIDTH-1:0]];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.clear) begin
         count_ff <= '0;
      end else if (ctrl.push) begin
         count_ff <= count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear) begin
         digits_ff[count_ff[itrd_pkg::DIDX_WIDTH-1:0]] <= push_digit;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_to_radix_digits_unit. Words and radices go
// in on the req channel. Each accepted word is spelled out here into the
// characters it should give: sign, then digits with the last one flagged.
// The rsp channel is checked character by character against them. Both
// sides insert random gaps. One long rsp hold-off makes the unit back up
// its input, and the sender pauses twice until the output has drained.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS     = 395;
   localparam int unsigned BURST_FIRST      = 200;   // random words sent back to back
   localparam int unsigned BURST_LAST       = 259;
   localparam int unsigned DRAIN_AT_A       = 120;   // sender waits for an empty pipe
   localparam int unsigned DRAIN_AT_B       = 300;
   localparam int unsigned LONG_HOLD_AT     = 150;   // characters seen before hold-off
   localparam int unsigned LONG_HOLD_CYCLES = 500;
   localparam int unsigned SETTLE_CYCLES    = 250;
   localparam logic [itrd_pkg::CHAR_WIDTH-1:0] GLYPH_ZERO = "0";
   localparam logic [itrd_pkg::CHAR_WIDTH-1:0] GLYPH_TEN  = "A";

   typedef struct {
      itrd_pkg::req_type word;
      int unsigned       gap_before;
      bit                drain_first;
   } queued_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   itrd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   itrd_pkg::rsp_type rsp_data;

   queued_word_type   words_to_send[$];
   itrd_pkg::rsp_type awaited_chars[$];
   int unsigned       error_count = 0;
   int unsigned       chars_seen = 0;
   int unsigned       wait_count = 0;
   int unsigned       hold_left = 0;
   int unsigned       free_left = 0;
   bit                long_hold_done = 1'b0;
   int unsigned       next_hold;
   itrd_pkg::rsp_type want;

   integer_to_radix_digits_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(40_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Expected characters of one word: optional '-', then digits MSD first.
   function automatic void spell_number(itrd_pkg::req_type w);
      logic [itrd_pkg::IN_WIDTH-1:0]   mag;
      int unsigned                     radix;
      int unsigned                     d;
      bit                              negative;
      logic [itrd_pkg::CHAR_WIDTH-1:0] glyphs[$];
      itrd_pkg::rsp_type               c;
      mag   = w.value_bits;
      radix = 32'(w.base);
      if (radix < itrd_pkg::MIN_RADIX) radix = 32'(itrd_pkg::MIN_RADIX);
      if (radix > itrd_pkg::MAX_RADIX) radix = 32'(itrd_pkg::MAX_RADIX);
      negative = (radix == itrd_pkg::DECIMAL_RADIX) && mag[itrd_pkg::IN_WIDTH-1];
      if (negative) mag = -mag;   // most negative value stays as its unsigned self
      do begin
         d = mag % radix;
         glyphs.push_front((d < 10) ? GLYPH_ZERO + itrd_pkg::CHAR_WIDTH'(d)
                                    : GLYPH_TEN + itrd_pkg::CHAR_WIDTH'(d - 10));
         mag = mag / radix;
      end while (mag != 0);
      if (negative) begin
         c.character = itrd_pkg::MINUS_CHAR;
         c.last      = 1'b0;
         awaited_chars.push_back(c);
      end
      foreach (glyphs[i]) begin
         c.character = glyphs[i];
         c.last      = (i == glyphs.size() - 1);
         awaited_chars.push_back(c);
      end
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned draw_pause();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [itrd_pkg::IN_WIDTH-1:0] random_word();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return $urandom();
      if (roll < 60) return $urandom_range(0, 300);
      if (roll < 70) return 32'h8000_0000 + $urandom_range(0, 50);
      if (roll < 78) return 32'h7FFF_FFFF - $urandom_range(0, 50);
      if (roll < 90) return -$urandom_range(1, 100000);
      return $urandom() >> $urandom_range(1, 31);
   endfunction

   function automatic logic [itrd_pkg::BASE_WIDTH-1:0] random_radix();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return itrd_pkg::DECIMAL_RADIX;
      if (roll < 85) begin
         return itrd_pkg::BASE_WIDTH'($urandom_range(itrd_pkg::MIN_RADIX,
                                                     itrd_pkg::MAX_RADIX));
      end
      return itrd_pkg::BASE_WIDTH'($urandom_range(0, 31));   // out-of-range radices saturate
   endfunction

   task automatic add_word(logic [itrd_pkg::IN_WIDTH-1:0] value,
                           logic [itrd_pkg::BASE_WIDTH-1:0] radix,
                           int unsigned gap, bit drain);
      queued_word_type q;
      q.word.value_bits = value;
      q.word.base       = radix;
      q.gap_before      = gap;
      q.drain_first     = drain;
      words_to_send.push_back(q);
   endtask

   // Sender: holds a stalled word, otherwise waits out its gap and presents the next.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         wait_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            spell_number(req_data);
         end
         if (req_valid && req_stall) begin
         end else if (words_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else if (wait_count < words_to_send[0].gap_before ||
                      (words_to_send[0].drain_first && awaited_chars.size() != 0)) begin
            req_valid  <= 1'b0;
            wait_count <= wait_count + 1;
         end else begin
            req_data   <= words_to_send[0].word;
            req_valid  <= 1'b1;
            wait_count <= 0;
            void'(words_to_send.pop_front());
         end
      end
   end

   // Receiver: checks each character transfer and paces rsp_stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         free_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            chars_seen++;
            if (awaited_chars.size() == 0) begin
               $display("%0t: unexpected character: got char=%h last=%b",
                        $time, rsp_data.character, rsp_data.last);
               error_count++;
            end else begin
               want = awaited_chars.pop_front();
               if (rsp_data.character !== want.character) begin
                  $display("%0t: character mismatch: expected %h, got %h",
                           $time, want.character, rsp_data.character);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last flag mismatch: expected %b, got %b",
                           $time, want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
         if (!long_hold_done && chars_seen >= LONG_HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES;
            rsp_stall      <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left <= free_left - 1;
            rsp_stall <= 1'b0;
         end else begin
            next_hold = $urandom_range(0, 1) ? draw_pause() : 0;
            rsp_stall <= (next_hold != 0);
            hold_left <= (next_hold != 0) ? next_hold - 1 : 0;
            free_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 12);
         end
      end
   end

   initial begin
      // zero, all ones, sign boundaries
      add_word(32'h0000_0000, itrd_pkg::MIN_RADIX, 0, 1'b0);
      add_word(32'h0000_0000, itrd_pkg::DECIMAL_RADIX, 0, 1'b0);
      add_word(32'h0000_0000, itrd_pkg::MAX_RADIX, 1, 1'b0);
      add_word(32'hFFFF_FFFF, itrd_pkg::MIN_RADIX, 0, 1'b0);
      add_word(32'hFFFF_FFFF, itrd_pkg::MAX_RADIX, 2, 1'b0);
      add_word(32'hFFFF_FFFF, itrd_pkg::DECIMAL_RADIX, 0, 1'b0);
      add_word(32'h8000_0000, itrd_pkg::DECIMAL_RADIX, 0, 1'b0);
      add_word(32'h8000_0000, itrd_pkg::MIN_RADIX, 3, 1'b0);
      add_word(32'h7FFF_FFFF, itrd_pkg::DECIMAL_RADIX, 0, 1'b0);
      // radices outside 2..16 saturate
      add_word(32'h0000_0005, 5'd0, 0, 1'b0);
      add_word(32'hA5A5_A5A5, 5'd1, 0, 1'b0);
      add_word(32'hFFFF_0000, 5'd17, 1, 1'b0);
      add_word(32'h1234_5678, 5'd31, 0, 1'b0);
      for (int b = 3; b < 16; b++) begin
         if (b != itrd_pkg::DECIMAL_RADIX) begin
            add_word(32'hFEDC_BA98 + 32'(b), itrd_pkg::BASE_WIDTH'(b),
                     $urandom_range(0, 2), 1'b0);
         end
      end
      for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
         add_word(random_word(), random_radix(),
                  (i >= BURST_FIRST && i <= BURST_LAST) ? 0
                     : ($urandom_range(0, 1) ? draw_pause() : 0),
                  (i == DRAIN_AT_A || i == DRAIN_AT_B));
      end

      @(posedge clock);
      while (reset || words_to_send.size() != 0 || req_valid ||
             awaited_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_chars.size() != 0) begin
         $display("%0t: %0d characters never arrived", $time, awaited_chars.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
